/* sv/tprs_pkg.sv */
// Shared types and constants for the twin prime range scanner.
// No dependencies; imported by tprs_prime_test and twin_prime_range_scanner.
package tprs_pkg;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST_LO,
      ST_WAIT_LO,
      ST_TEST_HI,
      ST_WAIT_HI,
      ST_EMIT
   } tprs_state_type;

   // States of the iterative primality test.
   typedef enum logic [1:0] {
      T_IDLE,
      T_CHECK,
      T_DIV,
      T_NEXT
   } tprs_test_state_type;

   // Status returned by the primality test; done is a one-cycle pulse.
   typedef struct packed {
      logic done;
      logic prime;
   } tprs_test_stat_type;

   // Configuration register indexes.
   localparam logic REG_RANGE_START = 1'b0;
   localparam logic REG_RANGE_END   = 1'b1;

endpackage

/* sv/tprs_prime_test.sv */
// Iterative primality test by trial division with odd divisors.
// A shared restoring remainder unit handles one bit of the value per cycle.
// Depends on tprs_pkg.
module tprs_prime_test #(
   parameter int NB = 18
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [NB-1:0]                value,
   output tprs_pkg::tprs_test_stat_type stat
);
   import tprs_pkg::*;

   localparam int CNTW = $clog2(NB);

   tprs_test_state_type state_ff, state_in;
   logic [NB-1:0]       val_ff, val_in;
   logic [NB-1:0]       d_ff, d_in;
   logic [NB:0]         sq_ff, sq_in;
   logic [NB-1:0]       rem_ff, rem_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic                prime_ff, prime_in;

   logic [NB:0]         trial;
   logic [NB:0]         d_ext;
   logic                fits;
   logic [NB-1:0]       rem_step;

   // One restoring step: bring down the next bit and subtract if it fits.
   assign trial    = {rem_ff, val_ff[cnt_ff]};
   assign d_ext    = {1'b0, d_ff};
   assign fits     = (trial >= d_ext);
   assign rem_step = fits ? NB'(trial - d_ext) : NB'(trial);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE: begin
            if (start) begin
               if ((value < NB'(2)) || (value == NB'(2)) || !value[0]) begin
                  state_in = T_IDLE;
               end else begin
                  state_in = T_CHECK;
               end
            end
         end
         T_CHECK: begin
            if (sq_ff > {1'b0, val_ff}) begin
               state_in = T_IDLE;
            end else begin
               state_in = T_DIV;
            end
         end
         T_DIV: begin
            if (cnt_ff == '0) begin
               state_in = T_NEXT;
            end
         end
         T_NEXT: begin
            if (rem_ff == '0) begin
               state_in = T_IDLE;
            end else begin
               state_in = T_CHECK;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      val_in   = val_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      prime_in = prime_ff;
      case (state_ff)
         T_IDLE: begin
            if (start) begin
               val_in = value;
               d_in   = NB'(3);
               sq_in  = (NB+1)'(9);
               if (value < NB'(2)) begin
                  done_in  = 1'b1;
                  prime_in = 1'b0;
               end else if (value == NB'(2)) begin
                  done_in  = 1'b1;
                  prime_in = 1'b1;
               end else if (!value[0]) begin
                  done_in  = 1'b1;
                  prime_in = 1'b0;
               end
            end
         end
         T_CHECK: begin
            if (sq_ff > {1'b0, val_ff}) begin
               done_in  = 1'b1;
               prime_in = 1'b1;
            end else begin
               rem_in = '0;
               cnt_in = CNTW'(NB-1);
            end
         end
         T_DIV: begin
            rem_in = rem_step;
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CNTW'(1);
            end
         end
         T_NEXT: begin
            if (rem_ff == '0) begin
               done_in  = 1'b1;
               prime_in = 1'b0;
            end else begin
               // (d + 2)^2 = d^2 + 4d + 4 keeps the bound without a multiplier.
               d_in  = d_ff + NB'(2);
               sq_in = sq_ff + (NB+1)'({d_ff, 2'b00}) + (NB+1)'(4);
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      val_ff   <= val_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
   end

   assign stat.done  = done_ff;
   assign stat.prime = prime_ff;

endmodule

/* sv/twin_prime_range_scanner.sv */
// Twin prime range scanner: one transaction tests candidate n and n+2 by trial division.
// Each odd divisor d with d*d <= v takes a full pass through the shared remainder unit, and
// the n+2 test runs only if n is prime. A done result skips the tests, and an even or small
// candidate needs no divisor. One transaction at a time; a result waits in the output.
// Synchronous reset clears both range registers and the candidate to zero.
module twin_prime_range_scanner #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_restart,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [15:0]      rsp_lower,
   output logic [16:0]      rsp_upper,
   output logic             rsp_is_twin,
   output logic             rsp_done_res,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [WIDTH-1:0] csr_wdata
);
   import tprs_pkg::*;

   localparam int CW = WIDTH + 1;
   localparam int NB = WIDTH + 2;

   tprs_state_type     state_ff, state_in;
   logic [WIDTH-1:0]   start_ff, end_ff;
   logic [CW-1:0]      cand_ff, cand_in;
   logic [CW-1:0]      n_ff, n_in;
   logic               done_ff, done_in;
   logic               twin_ff, twin_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        lower_ff, lower_in;
   logic [16:0]        upper_ff, upper_in;
   logic               is_twin_ff, is_twin_in;
   logic               done_res_ff, done_res_in;

   logic               accept;
   logic [CW-1:0]      start_odd;
   logic [CW-1:0]      cand_eff;
   logic [WIDTH-1:0]   last;
   logic               done_now;
   logic               out_free;
   logic [63:0]        n_wide;
   logic [63:0]        n2_wide;

   logic               test_start;
   logic [NB-1:0]      test_value;
   tprs_test_stat_type test_stat;

   tprs_prime_test #(
      .NB (NB)
   ) u_test (
      .clock (clock),
      .reset (reset),
      .start (test_start),
      .value (test_value),
      .stat  (test_stat)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Candidate after an optional restart, and the end of range check.
   assign start_odd = CW'(start_ff) + CW'(!start_ff[0]);
   assign cand_eff  = req_restart ? start_odd : cand_ff;
   assign last      = end_ff[0] ? end_ff : end_ff - WIDTH'(1);
   assign done_now  = (end_ff == '0) ||
                      (((CW+1)'(cand_eff) + (CW+1)'(2)) > (CW+1)'(last));

   assign n_wide  = 64'(n_ff);
   assign n2_wide = 64'(n_ff) + 64'd2;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = done_now ? ST_EMIT : ST_TEST_LO;
            end
         end
         ST_TEST_LO: state_in = ST_WAIT_LO;
         ST_WAIT_LO: begin
            if (test_stat.done) begin
               state_in = test_stat.prime ? ST_TEST_HI : ST_EMIT;
            end
         end
         ST_TEST_HI: state_in = ST_WAIT_HI;
         ST_WAIT_HI: begin
            if (test_stat.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cand_in      = cand_ff;
      n_in         = n_ff;
      done_in      = done_ff;
      twin_in      = twin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      is_twin_in   = is_twin_ff;
      done_res_in  = done_res_ff;
      test_start   = 1'b0;
      test_value   = NB'(n_ff);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in    = cand_eff;
               done_in = done_now;
               twin_in = 1'b0;
               cand_in = done_now ? cand_eff : CW'(cand_eff + CW'(2));
            end
         end
         ST_TEST_LO: begin
            test_start = 1'b1;
            test_value = NB'(n_ff);
         end
         ST_WAIT_LO: begin
            if (test_stat.done) begin
               twin_in = 1'b0;
            end
         end
         ST_TEST_HI: begin
            test_start = 1'b1;
            test_value = NB'(n_ff) + NB'(2);
         end
         ST_WAIT_HI: begin
            if (test_stat.done) begin
               twin_in = test_stat.prime;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               done_res_in  = done_ff;
               if (done_ff) begin
                  lower_in   = '0;
                  upper_in   = '0;
                  is_twin_in = 1'b0;
               end else begin
                  lower_in   = n_wide[15:0];
                  upper_in   = n2_wide[16:0];
                  is_twin_in = twin_ff;
               end
            end
         end
         default: begin
            test_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         end_ff       <= '0;
         cand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == REG_RANGE_START)) begin
            start_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == REG_RANGE_END)) begin
            end_ff <= csr_wdata;
         end
      end
      n_ff        <= n_in;
      done_ff     <= done_in;
      twin_ff     <= twin_in;
      lower_ff    <= lower_in;
      upper_ff    <= upper_in;
      is_twin_ff  <= is_twin_in;
      done_res_ff <= done_res_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_lower    = lower_ff;
   assign rsp_upper    = upper_ff;
   assign rsp_is_twin  = is_twin_ff;
   assign rsp_done_res = done_res_ff;

   // The sequencer holds off new transactions while a test is running.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("transaction accepted while the previous one is still in progress");

   // The test unit only finishes while the sequencer is waiting for it.
   assert property (@(posedge clock) disable iff (reset)
      test_stat.done |-> ((state_ff == ST_WAIT_LO) || (state_ff == ST_WAIT_HI)))
      else $error("primality test finished outside a wait state");

   // A done result carries zero fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> ((rsp_lower == '0) && (rsp_upper == '0) && !rsp_is_twin))
      else $error("done result with nonzero fields");

   // A test is started only for a candidate that lies inside the range.
   assert property (@(posedge clock) disable iff (reset)
      test_start |-> !done_ff)
      else $error("primality test started for an exhausted range");

endmodule
